// ----- src/smac_pkg.sv -----
// ----------------------------------------------------------------------------
// smac_pkg
// Shared constants, codes and types of the shadow memory access checker.
// ----------------------------------------------------------------------------
package smac_pkg;

   // guarded window and shadow map geometry
   localparam int unsigned WINDOW_BYTES = 65536;
   localparam int unsigned MAP_DEPTH    = (WINDOW_BYTES + 7) / 8;
   localparam int unsigned OFS_W        = $clog2(WINDOW_BYTES);
   localparam int unsigned BND_W        = OFS_W + 1;
   localparam int unsigned IDX_W        = OFS_W - 3;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned LEN_W  = 17;
   localparam int unsigned ADD_W  = ADDR_W + 1;
   localparam int unsigned CSR_W  = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // request operation codes
   localparam logic [1:0] OP_CHECK    = 2'd0;
   localparam logic [1:0] OP_POISON   = 2'd1;
   localparam logic [1:0] OP_UNPOISON = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_READS = 1'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFSET,
      ST_BOUNDS,
      ST_READ,
      ST_EVAL,
      ST_FAULT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              violation;
      logic [ADDR_W-1:0] fault_chunk_address;
      logic              fault_is_write;
   } result_type;

   typedef struct packed {
      logic [ADD_W-1:0] a;
      logic [ADD_W-1:0] b;
      logic             cin;
   } add_op_type;

endpackage

// ----- src/smac_adder.sv -----
// ----------------------------------------------------------------------------
// smac_adder
// Shared 33-bit adder with carry in, used by the sequencer for offsets,
// bounds, chunk stepping and fault addresses.
// ----------------------------------------------------------------------------
module smac_adder import smac_pkg::*; (
   input  add_op_type       op,
   output logic [ADD_W-1:0] sum
);

   assign sum = op.a + op.b + ADD_W'(op.cin);

endmodule

// ----- src/smac_seq.sv -----
// ----------------------------------------------------------------------------
// smac_seq
// Sequencer and shadow map: finds the in-window byte span of a request and
// walks it one shadow byte at a time, read-modify-write for poison/unpoison.
// ----------------------------------------------------------------------------
module smac_seq import smac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [ADDR_W-1:0] req_start_address,
   input  logic [LEN_W-1:0]  req_length,
   input  logic              req_is_write,
   input  logic [ADDR_W-1:0] window_base,
   input  logic              check_reads,
   output logic              res_valid,
   output result_type        res_data,
   input  logic              res_taken
);

   logic [7:0] shadow_mem [MAP_DEPTH];

   seq_state_type     state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              is_write_ff, is_write_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]  chunk_ff, chunk_in;
   logic [IDX_W-1:0]  first_chunk_ff, first_chunk_in;
   logic [2:0]        lo_bits_ff, lo_bits_in;
   logic [OFS_W-1:0]  last_ff, last_in;
   logic              clear_reply_ff, clear_reply_in;
   result_type        result_ff, result_in;
   logic [7:0]        rd_data_ff;

   add_op_type        add_op;
   logic [ADD_W-1:0]  add_sum;

   logic              mem_we;
   logic [7:0]        mem_wdata;

   logic              in_win;
   logic [ADD_W-1:0]  hi_big;
   logic [BND_W-1:0]  lo_v;
   logic [BND_W-1:0]  hi_v;
   logic [BND_W-1:0]  last_v;
   logic              nonempty;

   logic              first_hit;
   logic              last_hit;
   logic [7:0]        mask;
   logic              hit;

   smac_adder u_adder (
      .op  (add_op),
      .sum (add_sum)
   );

   // span of window offsets touched, valid while in ST_BOUNDS
   assign in_win   = acc_ff < ADDR_W'(WINDOW_BYTES);
   assign hi_big   = in_win ? add_sum : {1'b0, add_sum[ADDR_W-1:0]};
   assign lo_v     = in_win ? BND_W'(acc_ff) : '0;
   assign hi_v     = (hi_big > ADD_W'(WINDOW_BYTES)) ? BND_W'(WINDOW_BYTES)
                                                     : hi_big[BND_W-1:0];
   assign nonempty = (in_win || add_sum[ADD_W-1]) && (hi_v > lo_v);
   assign last_v   = hi_v - BND_W'(1);

   // byte mask of the current shadow byte
   assign first_hit = chunk_ff == first_chunk_ff;
   assign last_hit  = chunk_ff == last_ff[OFS_W-1:3];
   assign mask = (first_hit ? (8'hFF << lo_bits_ff) : 8'hFF) &
                 (last_hit ? (8'hFF >> (3'd7 - last_ff[2:0])) : 8'hFF);
   assign hit  = |(rd_data_ff & mask);

   assign res_data = result_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      len_in         = len_ff;
      is_write_in    = is_write_ff;
      acc_in         = acc_ff;
      chunk_in       = chunk_ff;
      first_chunk_in = first_chunk_ff;
      lo_bits_in     = lo_bits_ff;
      last_in        = last_ff;
      clear_reply_in = clear_reply_ff;
      result_in      = result_ff;
      add_op         = '0;
      mem_we         = 1'b0;
      mem_wdata      = rd_data_ff;
      req_stall      = 1'b1;
      res_valid      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            add_op    = '{a: ADD_W'(chunk_ff), b: ADD_W'(1), cin: 1'b0};
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (chunk_ff == IDX_W'(MAP_DEPTH - 1)) begin
               state_in = clear_reply_ff ? ST_DONE : ST_IDLE;
            end else begin
               chunk_in = add_sum[IDX_W-1:0];
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               acc_in         = req_start_address;
               op_in          = req_op;
               len_in         = req_length;
               is_write_in    = req_is_write;
               result_in      = '0;
               chunk_in       = '0;
               clear_reply_in = 1'b0;
               case (req_op)
                  OP_CLEAR: begin
                     clear_reply_in = 1'b1;
                     state_in       = ST_CLEAR;
                  end
                  OP_CHECK: begin
                     state_in = (req_is_write || check_reads) ? ST_OFFSET : ST_DONE;
                  end
                  default: begin
                     state_in = ST_OFFSET;
                  end
               endcase
            end
         end
         ST_OFFSET: begin
            // start minus window base
            add_op   = '{a: ADD_W'(acc_ff), b: ADD_W'(~window_base), cin: 1'b1};
            acc_in   = add_sum[ADDR_W-1:0];
            state_in = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            add_op         = '{a: ADD_W'(acc_ff), b: ADD_W'(len_ff), cin: 1'b0};
            chunk_in       = lo_v[OFS_W-1:3];
            first_chunk_in = lo_v[OFS_W-1:3];
            lo_bits_in     = lo_v[2:0];
            last_in        = last_v[OFS_W-1:0];
            state_in       = nonempty ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            add_op = '{a: ADD_W'(chunk_ff), b: ADD_W'(1), cin: 1'b0};
            case (op_ff)
               OP_POISON: begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff | mask;
               end
               OP_UNPOISON: begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff & ~mask;
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
            if (op_ff == OP_CHECK && hit) begin
               result_in.violation      = 1'b1;
               result_in.fault_is_write = is_write_ff;
               state_in                 = ST_FAULT;
            end else if (last_hit) begin
               state_in = ST_DONE;
            end else begin
               chunk_in = add_sum[IDX_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_FAULT: begin
            add_op = '{a: ADD_W'(window_base), b: ADD_W'({chunk_ff, 3'b000}), cin: 1'b0};
            result_in.fault_chunk_address = add_sum[ADDR_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         chunk_ff       <= '0;
         clear_reply_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chunk_ff       <= chunk_in;
         clear_reply_ff <= clear_reply_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      len_ff         <= len_in;
      is_write_ff    <= is_write_in;
      acc_ff         <= acc_in;
      first_chunk_ff <= first_chunk_in;
      lo_bits_ff     <= lo_bits_in;
      last_ff        <= last_in;
      result_ff      <= result_in;
   end

   // single-port shadow map, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[chunk_ff] <= mem_wdata;
      end
      rd_data_ff <= shadow_mem[chunk_ff];
   end

endmodule

// ----- src/shadow_memory_access_checker.sv -----
// ----------------------------------------------------------------------------
// shadow_memory_access_checker
// Keeps one poison bit per byte of a guarded window and checks, poisons
// or unpoisons byte ranges against it, or clears the whole map.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// req_      in         req_valid / req_stall  op, start_address, length, is_write
// rsp_      out        rsp_valid / rsp_stall  violation, fault_chunk_address,
//                                             fault_is_write
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// check, poison, unpoison: walk the shadow bytes of the range, a check stops
// at its first violation; the single-port shadow ram does a read for each
// byte, then a write for poison and unpoison. a read check with reads
// disabled, or a check with no byte in the window, walks no shadow byte.
// clear: writes every shadow byte, one ram write a cycle. after reset the
// same clearing pass runs with req_stall high. a stalled response is held in
// the output register while the next request is taken.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker import smac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [ADDR_W-1:0]    req_start_address,
   input  logic [LEN_W-1:0]     req_length,
   input  logic                 req_is_write,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_violation,
   output logic [ADDR_W-1:0]    rsp_fault_chunk_address,
   output logic                 rsp_fault_is_write,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   logic [ADDR_W-1:0] window_base_ff, window_base_in;
   logic              check_reads_ff, check_reads_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   logic              res_valid;
   result_type        res_data;
   logic              res_taken;

   smac_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_start_address (req_start_address),
      .req_length        (req_length),
      .req_is_write      (req_is_write),
      .window_base       (window_base_ff),
      .check_reads       (check_reads_ff),
      .res_valid         (res_valid),
      .res_data          (res_data),
      .res_taken         (res_taken)
   );

   // output register is free when empty or being drained
   assign res_taken = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      window_base_in = window_base_ff;
      check_reads_in = check_reads_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_BASE: window_base_in = csr_write_data[ADDR_W-1:0];
            CSR_CHECK_READS: check_reads_in = csr_write_data[0];
            default:         window_base_in = window_base_ff;
         endcase
      end

      rsp_data_in = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= '0;
         check_reads_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_base_ff <= window_base_in;
         check_reads_ff <= check_reads_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_violation           = rsp_data_ff.violation;
   assign rsp_fault_chunk_address = rsp_data_ff.fault_chunk_address;
   assign rsp_fault_is_write      = rsp_data_ff.fault_is_write;

endmodule

// ----- tb/shadow_memory_access_checker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_test
// Drives check, poison, unpoison and clear requests into the checker under
// bursty request timing and random response back-pressure. A local shadow
// bitmap predicts every response, which is compared field by field in order.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_test;
   import smac_pkg::*;

   localparam int STALL_NONE  = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;

   typedef struct {
      logic [1:0]        op;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
      logic              is_write;
   } shadow_request_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = OP_CHECK;
   logic [ADDR_W-1:0]    req_start_address = '0;
   logic [LEN_W-1:0]     req_length = '0;
   logic                 req_is_write = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_violation;
   logic [ADDR_W-1:0]    rsp_fault_chunk_address;
   logic                 rsp_fault_is_write;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_BASE;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // local copy of the shadow state and registers
   logic [7:0]        shadow_map [MAP_DEPTH];
   logic [ADDR_W-1:0] model_base;
   logic              model_check_reads;

   shadow_request_type pending_requests [$];
   result_type         expected_responses [$];
   result_type         wanted;

   int fault_count = 0;
   int mismatch_reports = 0;
   int results_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int holdoff_left = 0;
   int holdoff_mark = -1;
   int stall_mode = STALL_NONE;
   int mode_left = 0;

   shadow_memory_access_checker dut (.*);

   always #6 clock = ~clock;

   function automatic result_type predict_response(shadow_request_type r);
      result_type  res;
      logic [31:0] addr;
      logic [31:0] ofs;
      int unsigned i;
      res = '0;
      if (r.op == OP_CLEAR) begin
         foreach (shadow_map[k]) shadow_map[k] = '0;
      end else if (r.op == OP_POISON || r.op == OP_UNPOISON) begin
         for (i = 0; i < r.length; i++) begin
            addr = r.start + i;
            ofs  = addr - model_base;
            if (ofs < WINDOW_BYTES)
               shadow_map[ofs[OFS_W-1:3]][ofs[2:0]] = (r.op == OP_POISON);
         end
      end else if (r.is_write || model_check_reads) begin
         for (i = 0; i < r.length && !res.violation; i++) begin
            addr = r.start + i;
            ofs  = addr - model_base;
            if (ofs < WINDOW_BYTES && shadow_map[ofs[OFS_W-1:3]][ofs[2:0]]) begin
               res.violation           = 1'b1;
               res.fault_chunk_address = model_base + {ofs[31:3], 3'b000};
               res.fault_is_write      = r.is_write;
            end
         end
      end
      return res;
   endfunction

   // mostly small ranges clustered at the window start so checks hit poison
   function automatic shadow_request_type random_request();
      shadow_request_type r;
      int unsigned        pick;
      pick = $urandom_range(0, 99);
      if (pick < 2)       r.op = OP_CLEAR;
      else if (pick < 24) r.op = OP_POISON;
      else if (pick < 42) r.op = OP_UNPOISON;
      else                r.op = OP_CHECK;
      pick = $urandom_range(0, 99);
      if (pick < 60)      r.start = model_base + $urandom_range(0, 1023);
      else if (pick < 75) r.start = model_base + $urandom_range(0, WINDOW_BYTES - 1);
      else if (pick < 80) r.start = model_base + WINDOW_BYTES - 32 + $urandom_range(0, 63);
      else if (pick < 85) r.start = model_base - 32 + $urandom_range(0, 63);
      else                r.start = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 65)      r.length = LEN_W'($urandom_range(0, 16));
      else if (pick < 88) r.length = LEN_W'($urandom_range(17, 256));
      else if (pick < 97) r.length = LEN_W'($urandom_range(257, 2048));
      else if (pick < 99) r.length = LEN_W'($urandom_range(2049, 65535));
      else                r.length = LEN_W'(65536);
      r.is_write = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic push_request(input logic [1:0] op, input logic [31:0] start,
                               input int unsigned length, input logic is_write);
      shadow_request_type r;
      r.op       = op;
      r.start    = start;
      r.length   = LEN_W'(length);
      r.is_write = is_write;
      pending_requests.push_back(r);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == CSR_WINDOW_BASE)      model_base = data;
      else if (idx == CSR_CHECK_READS) model_check_reads = data[0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(predict_response(pending_requests.pop_front()));
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if ($urandom_range(0, 9) < 4)      gap_left = 0;
               else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 8);
               else                               gap_left = $urandom_range(9, 30);
            end
         end
         if (req_valid && req_stall) begin
            // stalled request stays as it is
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_valid         <= 1'b1;
            req_op            <= pending_requests[0].op;
            req_start_address <= pending_requests[0].start;
            req_length        <= pending_requests[0].length;
            req_is_write      <= pending_requests[0].is_write;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               fault_count++;
               if (mismatch_reports < 10) begin
                  mismatch_reports++;
                  $display("unexpected response: violation %0b chunk %h write %0b",
                           rsp_violation, rsp_fault_chunk_address, rsp_fault_is_write);
               end
            end else begin
               wanted = expected_responses.pop_front();
               if (rsp_violation !== wanted.violation ||
                   rsp_fault_chunk_address !== wanted.fault_chunk_address ||
                   rsp_fault_is_write !== wanted.fault_is_write) begin
                  fault_count++;
                  if (mismatch_reports < 10) begin
                     mismatch_reports++;
                     $display("response %0d mismatch: expected %0b/%h/%0b got %0b/%h/%0b",
                              results_seen, wanted.violation, wanted.fault_chunk_address,
                              wanted.fault_is_write, rsp_violation,
                              rsp_fault_chunk_address, rsp_fault_is_write);
                  end
               end
            end
            results_seen++;
         end
         // long hold-off twice in the run so the checker backs up
         if (holdoff_left == 0 && (results_seen == 60 || results_seen == 260) &&
             holdoff_mark != results_seen) begin
            holdoff_mark = results_seen;
            holdoff_left = 300 + $urandom_range(0, 200);
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
               mode_left  = $urandom_range(24, 160);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      foreach (shadow_map[k]) shadow_map[k] = '0;
      model_base        = '0;
      model_check_reads = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // let the power-up clearing pass finish
      repeat (2) @(posedge clock);
      while (req_stall) @(posedge clock);

      write_csr(CSR_WINDOW_BASE, 32'h0000_0000);
      write_csr(CSR_CHECK_READS, 32'd1);
      @(negedge clock);
      push_request(OP_CHECK,    32'h0000_0000, 0, 1'b1);
      push_request(OP_POISON,   32'h0000_0010, 5, 1'b0);
      push_request(OP_CHECK,    32'h0000_0000, 16, 1'b1);
      push_request(OP_CHECK,    32'h0000_0012, 1, 1'b0);
      push_request(OP_CHECK,    32'h0000_0015, 8, 1'b0);
      push_request(OP_CHECK,    32'h0000_0010, 0, 1'b1);
      push_request(OP_UNPOISON, 32'h0000_0012, 1, 1'b0);
      push_request(OP_CHECK,    32'h0000_0012, 1, 1'b1);
      push_request(OP_CHECK,    32'h0000_000F, 4, 1'b0);
      // range straddling the top of the window
      push_request(OP_POISON,   32'h0000_FFF8, 16, 1'b0);
      push_request(OP_CHECK,    32'h0000_FFF0, 32, 1'b0);
      push_request(OP_CHECK,    32'h0001_0000, 8, 1'b1);
      // range wrapping past the top of the address space
      push_request(OP_POISON,   32'hFFFF_FFF8, 16, 1'b1);
      push_request(OP_CHECK,    32'hFFFF_FFFC, 8, 1'b1);
      push_request(OP_CLEAR,    32'hFFFF_FFFF, 65536, 1'b1);
      push_request(OP_CHECK,    32'h0000_0000, 65536, 1'b0);
      push_request(OP_POISON,   32'hFFFF_FFFF, 1, 1'b0);
      push_request(OP_POISON,   32'h0000_0000, 65536, 1'b0);
      push_request(OP_CHECK,    32'h0000_8000, 1, 1'b0);
      push_request(OP_UNPOISON, 32'h0000_0000, 65536, 1'b1);
      push_request(OP_CHECK,    32'h0000_0000, 65536, 1'b1);
      push_request(OP_POISON,   32'h0000_7FFF, 1, 1'b0);
      push_request(OP_CHECK,    32'hFFFF_FFFF, 65536, 1'b0);
      wait_idle();

      // reads not checked
      write_csr(CSR_CHECK_READS, 32'd0);
      @(negedge clock);
      push_request(OP_POISON, 32'h0000_0040, 1, 1'b0);
      push_request(OP_CHECK,  32'h0000_0040, 1, 1'b0);
      push_request(OP_CHECK,  32'h0000_0040, 1, 1'b1);
      repeat (80) pending_requests.push_back(random_request());
      wait_idle();

      // window wrapping through address zero
      write_csr(CSR_WINDOW_BASE, 32'hFFFF_8000);
      write_csr(CSR_CHECK_READS, 32'd1);
      @(negedge clock);
      repeat (90) pending_requests.push_back(random_request());
      wait_idle();

      write_csr(CSR_WINDOW_BASE, 32'hFFFF_FFFF);
      @(negedge clock);
      repeat (80) pending_requests.push_back(random_request());
      wait_idle();

      write_csr(CSR_WINDOW_BASE, $urandom);
      write_csr(CSR_CHECK_READS, $urandom_range(0, 1));
      @(negedge clock);
      repeat (90) pending_requests.push_back(random_request());
      wait_idle();

      write_csr(CSR_WINDOW_BASE, $urandom);
      write_csr(CSR_CHECK_READS, 32'd1);
      @(negedge clock);
      repeat (90) pending_requests.push_back(random_request());
      wait_idle();

      repeat (16) @(posedge clock);
      if (fault_count == 0 && expected_responses.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- shadow_memory_access_checker.f -----
src/smac_pkg.sv
src/smac_adder.sv
src/smac_seq.sv
src/shadow_memory_access_checker.sv
tb/shadow_memory_access_checker_test.sv
